@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the lobe select block.
// No dependencies; each macro clocks on the rising edge and holds off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FGLS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication.
`define FGLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/fgls_pkg.sv @@
// Package of the Fresnel glass lobe select block: widths, codes, sideband types.
// No dependencies; the interfaces, top level, checker and testbench use it by scoped names.
package fgls_pkg;

    localparam int COS_W     = 16;
    localparam int U_W       = 16;
    localparam int IOR_W     = 14;
    localparam int Q16_W     = 17;
    localparam int LOBE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 17;

    // sin^2(theta_t) divider
    localparam int ST_NUM_W  = 55;
    localparam int ST_DEN_W  = 28;
    localparam int ST_Q_W    = 30;
    // cos(theta_t) square root
    localparam int SQ_IN_W   = 31;
    localparam int CT_W      = 16;
    // amplitude ratio dividers
    localparam int RT_AB_W   = 30;
    localparam int RT_NUM_W  = 46;
    localparam int RT_DEN_W  = 31;
    // lobe normalization dividers
    localparam int NM_NUM_W  = 33;
    localparam int NM_DEN_W  = 17;

    localparam logic [COS_W-1:0] COS_ONE     = 16'd32768;
    localparam logic [Q16_W-1:0] Q16_ONE     = 17'd65536;
    localparam logic [Q16_W-1:0] DELTA_LIMIT = 17'd1311;
    localparam logic [Q16_W-1:0] PDF_FLOOR   = 17'd6;
    localparam logic [IOR_W-1:0] IOR_RESET   = 14'd6144;
    localparam logic [IOR_W-1:0] IOR_MIN     = 14'd1;

    localparam logic [LOBE_W-1:0] LOBE_REFLECT  = 2'd0;
    localparam logic [LOBE_W-1:0] LOBE_TRANSMIT = 2'd1;
    localparam logic [LOBE_W-1:0] LOBE_NONE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_IOR          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUGHNESS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSMISSION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_RED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE    = 3'd5;

    typedef struct packed {
        logic [COS_W-1:0] c;
        logic [U_W-1:0]   u;
        logic             tir;
    } st_side_t;

    typedef struct packed {
        logic [U_W-1:0] u;
        logic           tir;
        logic           zero;
    } rt_side_t;

    typedef struct packed {
        logic [Q16_W-1:0] fresnel;
        logic             none;
    } nm_side_t;

    function automatic logic [Q16_W-1:0] sat_q16(input logic [Q16_W-1:0] v);
        return (v > Q16_ONE) ? Q16_ONE : v;
    endfunction

endpackage

@@ rtl/fgls_sample_if.sv @@
// Input channel of the lobe select block: one shading sample per transaction.
// Depends on fgls_pkg for field widths.
interface fgls_sample_if;
    logic                         valid;
    logic                         ready;
    logic [fgls_pkg::COS_W-1:0]   cos_incident;
    logic [fgls_pkg::U_W-1:0]     rand_u;

    modport source (output valid, cos_incident, rand_u, input ready);
    modport sink   (input valid, cos_incident, rand_u, output ready);
endinterface

@@ rtl/fgls_result_if.sv @@
// Output channel of the lobe select block: one lobe choice per transaction.
// Depends on fgls_pkg for field widths.
interface fgls_result_if;
    logic                          valid;
    logic                          ready;
    logic [fgls_pkg::Q16_W-1:0]    fresnel;
    logic [fgls_pkg::LOBE_W-1:0]   lobe;
    logic                          delta_flag;
    logic [fgls_pkg::Q16_W-1:0]    weight_red;
    logic [fgls_pkg::Q16_W-1:0]    weight_green;
    logic [fgls_pkg::Q16_W-1:0]    weight_blue;
    logic [fgls_pkg::Q16_W-1:0]    pdf;

    modport source (output valid, fresnel, lobe, delta_flag, weight_red, weight_green,
                     weight_blue, pdf, input ready);
    modport sink   (input valid, fresnel, lobe, delta_flag, weight_red, weight_green,
                    weight_blue, pdf, output ready);
endinterface

@@ rtl/fgls_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Requires num < den * 2^Q_W; carries a sideband word alongside. No dependencies.
module fgls_div_pipe #(
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 8,
    parameter int Q_W    = 8,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic [SIDE_W-1:0] side_out
);

    localparam int REM_W = DEN_W + Q_W;

    logic [REM_W-1:0]  rem_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [Q_W-1:0]    quo_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic [Q_W-1:0]    valid_reg;

    logic [REM_W-1:0]  rem_src  [Q_W];
    logic [DEN_W-1:0]  den_src  [Q_W];
    logic [Q_W-1:0]    quo_src  [Q_W];
    logic [SIDE_W-1:0] side_src [Q_W];
    logic [Q_W-1:0]    valid_src;
    logic [REM_W-1:0]  rem_next [Q_W];
    logic [Q_W-1:0]    quo_next [Q_W];

    always_comb
    begin
        rem_src[0]   = REM_W'(num);
        den_src[0]   = den;
        quo_src[0]   = '0;
        side_src[0]  = side_in;
        valid_src[0] = in_valid;
        for (int s = 1; s < Q_W; s++)
        begin
            rem_src[s]   = rem_reg[s-1];
            den_src[s]   = den_reg[s-1];
            quo_src[s]   = quo_reg[s-1];
            side_src[s]  = side_reg[s-1];
            valid_src[s] = valid_reg[s-1];
        end
    end

    always_comb
    begin
        logic [REM_W-1:0] trial;
        logic [REM_W:0]   diff;
        for (int s = 0; s < Q_W; s++)
        begin
            trial = REM_W'(den_src[s]) << (Q_W - 1 - s);
            diff  = {1'b0, rem_src[s]} - {1'b0, trial};
            if (diff[REM_W])
            begin
                rem_next[s] = rem_src[s];
                quo_next[s] = quo_src[s];
            end
            else
            begin
                rem_next[s] = diff[REM_W-1:0];
                quo_next[s] = quo_src[s] | (Q_W'(1) << (Q_W - 1 - s));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_src;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < Q_W; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                quo_reg[s]  <= quo_next[s];
                den_reg[s]  <= den_src[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quo       = quo_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

@@ rtl/fgls_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per register stage.
// Floor of the root of an IN_W-bit value, sideband carried alongside. No dependencies.
module fgls_sqrt_pipe #(
    parameter int IN_W   = 31,
    parameter int SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [IN_W-1:0]           radicand,
    input  logic [SIDE_W-1:0]         side_in,
    output logic                      out_valid,
    output logic [(IN_W+1)/2-1:0]     root,
    output logic [SIDE_W-1:0]         side_out
);

    localparam int STEPS = (IN_W + 1) / 2;
    localparam int ACC_W = 2 * STEPS + 1;

    logic [ACC_W-1:0]  v_reg    [STEPS];
    logic [ACC_W-1:0]  res_reg  [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic [STEPS-1:0]  valid_reg;

    logic [ACC_W-1:0]  v_src    [STEPS];
    logic [ACC_W-1:0]  res_src  [STEPS];
    logic [SIDE_W-1:0] side_src [STEPS];
    logic [STEPS-1:0]  valid_src;
    logic [ACC_W-1:0]  v_next   [STEPS];
    logic [ACC_W-1:0]  res_next [STEPS];

    always_comb
    begin
        v_src[0]     = ACC_W'(radicand);
        res_src[0]   = '0;
        side_src[0]  = side_in;
        valid_src[0] = in_valid;
        for (int s = 1; s < STEPS; s++)
        begin
            v_src[s]     = v_reg[s-1];
            res_src[s]   = res_reg[s-1];
            side_src[s]  = side_reg[s-1];
            valid_src[s] = valid_reg[s-1];
        end
    end

    always_comb
    begin
        logic [ACC_W-1:0] bitv;
        logic [ACC_W-1:0] sum;
        logic [ACC_W:0]   diff;
        for (int s = 0; s < STEPS; s++)
        begin
            bitv = ACC_W'(1) << (2 * (STEPS - 1 - s));
            sum  = res_src[s] + bitv;
            diff = {1'b0, v_src[s]} - {1'b0, sum};
            if (diff[ACC_W])
            begin
                v_next[s]   = v_src[s];
                res_next[s] = res_src[s] >> 1;
            end
            else
            begin
                v_next[s]   = diff[ACC_W-1:0];
                res_next[s] = (res_src[s] >> 1) + bitv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_src;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < STEPS; s++)
            begin
                v_reg[s]    <= v_next[s];
                res_reg[s]  <= res_next[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign root      = res_reg[STEPS-1][STEPS-1:0];
    assign side_out  = side_reg[STEPS-1];

endmodule

@@ rtl/fresnel_glass_lobe_select.sv @@
// Top level of the Fresnel glass lobe select block.
// Depends on fgls_pkg, fgls_sample_if, fgls_result_if, fgls_div_pipe, fgls_sqrt_pipe.
//
// Usage:
//   sample : valid/ready channel, cos_incident (Q1.15) and rand_u (Q0.16).
//   result : valid/ready channel, fresnel, lobe, delta_flag, three weights, pdf.
//   cfg    : cfg_we/cfg_index/cfg_data writes ior, roughness, transmission, tints;
//            write only while no transaction is in flight.
// Path: a sample, once accepted, is carried through the pipeline; the path is
//   three front stages, a 30-stage divider for sin^2 of the refracted angle,
//   a 16-stage square root, two product stages, two 17-stage ratio dividers in
//   parallel, four combine stages, two 17-stage normalizing dividers, and two
//   output stages.
// Throughput: one sample per cycle while not stalled, every stage taking a new one.
// Stall: all stages advance together whenever the output register is empty or being
//   taken; while the receiver holds ready low with a result waiting, the pipeline
//   freezes and sample.ready is low, nothing is lost or repeated.
// Reset: clears every valid bit and loads the register defaults (ior 1.5,
//   roughness 0, transmission and tints 1.0). No clearing pass is needed.
module fresnel_glass_lobe_select (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fgls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fgls_pkg::CFG_W-1:0]       cfg_data,
    fgls_sample_if.sink                      sample,
    fgls_result_if.source                    result
);

    localparam int Q = fgls_pkg::Q16_W;

    // Configuration registers
    logic [fgls_pkg::IOR_W-1:0] ior_reg;
    logic [Q-1:0]               roughness_reg;
    logic [Q-1:0]               transmission_reg;
    logic [Q-1:0]               tint_red_reg;
    logic [Q-1:0]               tint_green_reg;
    logic [Q-1:0]               tint_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ior_reg          <= fgls_pkg::IOR_RESET;
            roughness_reg    <= '0;
            transmission_reg <= fgls_pkg::Q16_ONE;
            tint_red_reg     <= fgls_pkg::Q16_ONE;
            tint_green_reg   <= fgls_pkg::Q16_ONE;
            tint_blue_reg    <= fgls_pkg::Q16_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fgls_pkg::REG_IOR:          ior_reg          <= cfg_data[fgls_pkg::IOR_W-1:0];
                fgls_pkg::REG_ROUGHNESS:    roughness_reg    <= cfg_data;
                fgls_pkg::REG_TRANSMISSION: transmission_reg <= cfg_data;
                fgls_pkg::REG_TINT_RED:     tint_red_reg     <= cfg_data;
                fgls_pkg::REG_TINT_GREEN:   tint_green_reg   <= cfg_data;
                fgls_pkg::REG_TINT_BLUE:    tint_blue_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [fgls_pkg::IOR_W-1:0] eta;
    logic [Q-1:0]               trans_sat;
    logic [Q-1:0]               tint_red_sat;
    logic [Q-1:0]               tint_green_sat;
    logic [Q-1:0]               tint_blue_sat;

    assign eta            = (ior_reg == '0) ? fgls_pkg::IOR_MIN : ior_reg;
    assign trans_sat      = fgls_pkg::sat_q16(transmission_reg);
    assign tint_red_sat   = fgls_pkg::sat_q16(tint_red_reg);
    assign tint_green_sat = fgls_pkg::sat_q16(tint_green_reg);
    assign tint_blue_sat  = fgls_pkg::sat_q16(tint_blue_reg);

    logic adv;
    logic o_valid_reg;

    assign adv          = !o_valid_reg || result.ready;
    assign sample.ready = adv;

    // Stage A: clamp cosine
    logic                       a_valid_reg;
    logic [fgls_pkg::COS_W-1:0] a_c_reg;
    logic [fgls_pkg::U_W-1:0]   a_u_reg;

    // Stage B: squares
    logic                       b_valid_reg;
    logic [30:0]                b_c2_reg;
    logic [fgls_pkg::ST_DEN_W-1:0] b_eta2_reg;
    logic [fgls_pkg::COS_W-1:0] b_c_reg;
    logic [fgls_pkg::U_W-1:0]   b_u_reg;

    // Stage C: divider operands
    logic                          c_valid_reg;
    logic [fgls_pkg::ST_NUM_W-1:0] c_num_reg;
    logic [fgls_pkg::ST_DEN_W-1:0] c_den_reg;
    fgls_pkg::st_side_t            c_side_reg;

    logic [30:0] s2;
    logic        tir;

    assign s2  = 31'h4000_0000 - b_c2_reg;
    assign tir = {3'b0, s2} >= {b_eta2_reg, 6'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= sample.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_c_reg    <= (sample.cos_incident > fgls_pkg::COS_ONE) ? fgls_pkg::COS_ONE
                                                                    : sample.cos_incident;
            a_u_reg    <= sample.rand_u;
            b_c2_reg   <= 31'(a_c_reg) * 31'(a_c_reg);
            b_eta2_reg <= fgls_pkg::ST_DEN_W'(eta) * fgls_pkg::ST_DEN_W'(eta);
            b_c_reg    <= a_c_reg;
            b_u_reg    <= a_u_reg;
            c_num_reg  <= tir ? '0 : {s2, 24'b0};
            c_den_reg  <= b_eta2_reg;
            c_side_reg <= '{c: b_c_reg, u: b_u_reg, tir: tir};
        end
    end

    // sin^2 of the refracted angle
    logic                        st_valid;
    logic [fgls_pkg::ST_Q_W-1:0] st2;
    fgls_pkg::st_side_t          st_side;

    fgls_div_pipe #(
        .NUM_W  (fgls_pkg::ST_NUM_W),
        .DEN_W  (fgls_pkg::ST_DEN_W),
        .Q_W    (fgls_pkg::ST_Q_W),
        .SIDE_W ($bits(fgls_pkg::st_side_t))
    ) u_st_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c_valid_reg),
        .num       (c_num_reg),
        .den       (c_den_reg),
        .side_in   (c_side_reg),
        .out_valid (st_valid),
        .quo       (st2),
        .side_out  (st_side)
    );

    // cos of the refracted angle
    logic [fgls_pkg::SQ_IN_W-1:0] ct2;
    logic                         ct_valid;
    logic [fgls_pkg::CT_W-1:0]    ct;
    fgls_pkg::st_side_t           ct_side;

    assign ct2 = 31'h4000_0000 - {1'b0, st2};

    fgls_sqrt_pipe #(
        .IN_W   (fgls_pkg::SQ_IN_W),
        .SIDE_W ($bits(fgls_pkg::st_side_t))
    ) u_ct_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (st_valid),
        .radicand  (ct2),
        .side_in   (st_side),
        .out_valid (ct_valid),
        .root      (ct),
        .side_out  (ct_side)
    );

    // Stage E: amplitude terms
    logic                         e_valid_reg;
    logic [fgls_pkg::RT_AB_W-1:0] e_a_reg;
    logic [fgls_pkg::RT_AB_W-1:0] e_b_reg;
    logic [fgls_pkg::RT_AB_W-1:0] e_p_reg;
    logic [fgls_pkg::RT_AB_W-1:0] e_q_reg;
    logic [fgls_pkg::U_W-1:0]     e_u_reg;
    logic                         e_tir_reg;

    // Stage G: ratio divider operands
    logic                          g_valid_reg;
    logic [fgls_pkg::RT_NUM_W-1:0] g_num1_reg;
    logic [fgls_pkg::RT_DEN_W-1:0] g_den1_reg;
    logic [fgls_pkg::RT_NUM_W-1:0] g_num2_reg;
    logic [fgls_pkg::RT_DEN_W-1:0] g_den2_reg;
    fgls_pkg::rt_side_t            g_side1_reg;
    logic                          g_zero2_reg;

    logic [fgls_pkg::RT_DEN_W-1:0] den1;
    logic [fgls_pkg::RT_DEN_W-1:0] den2;
    logic [fgls_pkg::RT_AB_W-1:0]  diff1;
    logic [fgls_pkg::RT_AB_W-1:0]  diff2;

    assign den1  = fgls_pkg::RT_DEN_W'(e_a_reg) + fgls_pkg::RT_DEN_W'(e_b_reg);
    assign den2  = fgls_pkg::RT_DEN_W'(e_p_reg) + fgls_pkg::RT_DEN_W'(e_q_reg);
    assign diff1 = (e_a_reg > e_b_reg) ? e_a_reg - e_b_reg : e_b_reg - e_a_reg;
    assign diff2 = (e_p_reg > e_q_reg) ? e_p_reg - e_q_reg : e_q_reg - e_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= ct_valid;
            g_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_a_reg     <= fgls_pkg::RT_AB_W'(eta) * fgls_pkg::RT_AB_W'(ct_side.c);
            e_b_reg     <= {2'b0, ct, 12'b0};
            e_p_reg     <= {2'b0, ct_side.c, 12'b0};
            e_q_reg     <= fgls_pkg::RT_AB_W'(eta) * fgls_pkg::RT_AB_W'(ct);
            e_u_reg     <= ct_side.u;
            e_tir_reg   <= ct_side.tir;
            g_num1_reg  <= {diff1, 16'b0};
            g_den1_reg  <= den1;
            g_num2_reg  <= {diff2, 16'b0};
            g_den2_reg  <= den2;
            g_side1_reg <= '{u: e_u_reg, tir: e_tir_reg, zero: (den1 == '0)};
            g_zero2_reg <= (den2 == '0);
        end
    end

    // Parallel and perpendicular amplitude ratios
    logic               r1_valid;
    logic               r2_valid;
    logic [Q-1:0]       q1;
    logic [Q-1:0]       q2;
    fgls_pkg::rt_side_t r1_side;
    logic               r2_zero;

    fgls_div_pipe #(
        .NUM_W  (fgls_pkg::RT_NUM_W),
        .DEN_W  (fgls_pkg::RT_DEN_W),
        .Q_W    (Q),
        .SIDE_W ($bits(fgls_pkg::rt_side_t))
    ) u_r1_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (g_valid_reg),
        .num       (g_num1_reg),
        .den       (g_den1_reg),
        .side_in   (g_side1_reg),
        .out_valid (r1_valid),
        .quo       (q1),
        .side_out  (r1_side)
    );

    fgls_div_pipe #(
        .NUM_W  (fgls_pkg::RT_NUM_W),
        .DEN_W  (fgls_pkg::RT_DEN_W),
        .Q_W    (Q),
        .SIDE_W (1)
    ) u_r2_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (g_valid_reg),
        .num       (g_num2_reg),
        .den       (g_den2_reg),
        .side_in   (g_zero2_reg),
        .out_valid (r2_valid),
        .quo       (q2),
        .side_out  (r2_zero)
    );

    // Stages H..K: reflectance, transmit probability, normalizer operands
    logic                      h_valid_reg;
    logic [2*Q-1:0]            h_sq1_reg;
    logic [2*Q-1:0]            h_sq2_reg;
    logic [fgls_pkg::U_W-1:0]  h_u_reg;
    logic                      h_tir_reg;
    logic                      i_valid_reg;
    logic [Q-1:0]              i_f_reg;
    logic [fgls_pkg::U_W-1:0]  i_u_reg;
    logic                      j_valid_reg;
    logic [Q-1:0]              j_f_reg;
    logic [Q-1:0]              j_t_reg;
    logic [fgls_pkg::U_W-1:0]  j_u_reg;
    logic                      k_valid_reg;
    logic [fgls_pkg::NM_NUM_W-1:0] k_num_r_reg;
    logic [fgls_pkg::NM_NUM_W-1:0] k_num_t_reg;
    logic [fgls_pkg::NM_DEN_W-1:0] k_den_reg;
    fgls_pkg::nm_side_t        k_side_reg;
    logic [fgls_pkg::U_W-1:0]  k_u_reg;

    logic [Q-1:0]   r1;
    logic [Q-1:0]   r2;
    logic [2*Q:0]   sq_sum;
    logic [Q:0]     f_raw;
    logic [Q-1:0]   f_next;
    logic [2*Q-1:0] t_prod;
    logic [Q-1:0]   total;

    assign r1     = r1_side.zero ? fgls_pkg::Q16_ONE : q1;
    assign r2     = r2_zero ? fgls_pkg::Q16_ONE : q2;
    assign sq_sum = (2*Q+1)'(h_sq1_reg) + (2*Q+1)'(h_sq2_reg);
    assign f_raw  = sq_sum[2*Q:Q];
    assign f_next = h_tir_reg ? fgls_pkg::Q16_ONE
                  : ((f_raw > (Q+1)'(fgls_pkg::Q16_ONE)) ? fgls_pkg::Q16_ONE : f_raw[Q-1:0]);
    assign t_prod = (2*Q)'(fgls_pkg::Q16_ONE - i_f_reg) * (2*Q)'(trans_sat);
    assign total  = j_f_reg + j_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
            j_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            h_valid_reg <= r1_valid && r2_valid;
            i_valid_reg <= h_valid_reg;
            j_valid_reg <= i_valid_reg;
            k_valid_reg <= j_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_sq1_reg   <= (2*Q)'(r1) * (2*Q)'(r1);
            h_sq2_reg   <= (2*Q)'(r2) * (2*Q)'(r2);
            h_u_reg     <= r1_side.u;
            h_tir_reg   <= r1_side.tir;
            i_f_reg     <= f_next;
            i_u_reg     <= h_u_reg;
            j_f_reg     <= i_f_reg;
            j_t_reg     <= t_prod[Q+15:16];
            j_u_reg     <= i_u_reg;
            k_num_r_reg <= {j_f_reg, 16'b0};
            k_num_t_reg <= {j_t_reg, 16'b0};
            k_den_reg   <= total;
            k_side_reg  <= '{fresnel: j_f_reg, none: (total == '0)};
            k_u_reg     <= j_u_reg;
        end
    end

    // Normalized reflect and transmit probabilities
    logic               rn_valid;
    logic               tn_valid;
    logic [Q-1:0]       rn;
    logic [Q-1:0]       tn;
    fgls_pkg::nm_side_t nm_side;
    logic [fgls_pkg::U_W-1:0] nm_u;

    fgls_div_pipe #(
        .NUM_W  (fgls_pkg::NM_NUM_W),
        .DEN_W  (fgls_pkg::NM_DEN_W),
        .Q_W    (Q),
        .SIDE_W ($bits(fgls_pkg::nm_side_t))
    ) u_rn_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (k_valid_reg),
        .num       (k_num_r_reg),
        .den       (k_den_reg),
        .side_in   (k_side_reg),
        .out_valid (rn_valid),
        .quo       (rn),
        .side_out  (nm_side)
    );

    fgls_div_pipe #(
        .NUM_W  (fgls_pkg::NM_NUM_W),
        .DEN_W  (fgls_pkg::NM_DEN_W),
        .Q_W    (Q),
        .SIDE_W (fgls_pkg::U_W)
    ) u_tn_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (k_valid_reg),
        .num       (k_num_t_reg),
        .den       (k_den_reg),
        .side_in   (k_u_reg),
        .out_valid (tn_valid),
        .quo       (tn),
        .side_out  (nm_u)
    );

    // Stage L: tinted transmit weights
    logic                     l_valid_reg;
    logic [Q-1:0]             l_wr_reg;
    logic [Q-1:0]             l_wg_reg;
    logic [Q-1:0]             l_wb_reg;
    logic [Q-1:0]             l_rn_reg;
    logic [Q-1:0]             l_tn_reg;
    logic [Q-1:0]             l_f_reg;
    logic                     l_none_reg;
    logic [fgls_pkg::U_W-1:0] l_u_reg;

    logic [2*Q-1:0] wr_prod;
    logic [2*Q-1:0] wg_prod;
    logic [2*Q-1:0] wb_prod;

    assign wr_prod = (2*Q)'(tint_red_sat) * (2*Q)'(tn);
    assign wg_prod = (2*Q)'(tint_green_sat) * (2*Q)'(tn);
    assign wb_prod = (2*Q)'(tint_blue_sat) * (2*Q)'(tn);

    // Stage M: lobe choice and output register
    logic [Q-1:0]                o_fresnel_reg;
    logic [fgls_pkg::LOBE_W-1:0] o_lobe_reg;
    logic                        o_delta_reg;
    logic [Q-1:0]                o_wr_reg;
    logic [Q-1:0]                o_wg_reg;
    logic [Q-1:0]                o_wb_reg;
    logic [Q-1:0]                o_pdf_reg;

    logic [fgls_pkg::LOBE_W-1:0] lobe_next;
    logic [Q-1:0]                wr_next;
    logic [Q-1:0]                wg_next;
    logic [Q-1:0]                wb_next;
    logic [Q-1:0]                pdf_next;

    always_comb
    begin
        if (l_none_reg)
        begin
            lobe_next = fgls_pkg::LOBE_NONE;
            wr_next   = '0;
            wg_next   = '0;
            wb_next   = '0;
            pdf_next  = fgls_pkg::Q16_ONE;
        end
        else if (Q'(l_u_reg) < l_rn_reg)
        begin
            lobe_next = fgls_pkg::LOBE_REFLECT;
            wr_next   = l_rn_reg;
            wg_next   = l_rn_reg;
            wb_next   = l_rn_reg;
            pdf_next  = (l_rn_reg < fgls_pkg::PDF_FLOOR) ? fgls_pkg::PDF_FLOOR : l_rn_reg;
        end
        else
        begin
            lobe_next = fgls_pkg::LOBE_TRANSMIT;
            wr_next   = l_wr_reg;
            wg_next   = l_wg_reg;
            wb_next   = l_wb_reg;
            pdf_next  = (l_tn_reg < fgls_pkg::PDF_FLOOR) ? fgls_pkg::PDF_FLOOR : l_tn_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            l_valid_reg <= rn_valid && tn_valid;
            o_valid_reg <= l_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_wr_reg      <= wr_prod[Q+15:16];
            l_wg_reg      <= wg_prod[Q+15:16];
            l_wb_reg      <= wb_prod[Q+15:16];
            l_rn_reg      <= rn;
            l_tn_reg      <= tn;
            l_f_reg       <= nm_side.fresnel;
            l_none_reg    <= nm_side.none;
            l_u_reg       <= nm_u;
            o_fresnel_reg <= l_f_reg;
            o_lobe_reg    <= lobe_next;
            o_delta_reg   <= (roughness_reg < fgls_pkg::DELTA_LIMIT);
            o_wr_reg      <= wr_next;
            o_wg_reg      <= wg_next;
            o_wb_reg      <= wb_next;
            o_pdf_reg     <= pdf_next;
        end
    end

    assign result.valid        = o_valid_reg;
    assign result.fresnel      = o_fresnel_reg;
    assign result.lobe         = o_lobe_reg;
    assign result.delta_flag   = o_delta_reg;
    assign result.weight_red   = o_wr_reg;
    assign result.weight_green = o_wg_reg;
    assign result.weight_blue  = o_wb_reg;
    assign result.pdf          = o_pdf_reg;

endmodule

@@ rtl/fgls_checker.sv @@
// Port-level checker of the lobe select block and its bind to the top level.
// Depends on fgls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fgls_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           valid,
    input logic                           ready,
    input logic [fgls_pkg::Q16_W-1:0]     fresnel,
    input logic [fgls_pkg::LOBE_W-1:0]    lobe,
    input logic [fgls_pkg::Q16_W-1:0]     weight_red,
    input logic [fgls_pkg::Q16_W-1:0]     weight_green,
    input logic [fgls_pkg::Q16_W-1:0]     weight_blue,
    input logic [fgls_pkg::Q16_W-1:0]     pdf
);

    `FGLS_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, valid && !ready, valid && $stable(pdf) && $stable(lobe) && $stable(weight_red))

    `FGLS_ASSERT_IMPLY(a_no_lobe, clk, rst_n, valid && lobe == fgls_pkg::LOBE_NONE, pdf == fgls_pkg::Q16_ONE && weight_red == '0 && weight_green == '0 && weight_blue == '0)

    `FGLS_ASSERT_IMPLY(a_pdf_floor, clk, rst_n, valid && lobe != fgls_pkg::LOBE_NONE, pdf >= fgls_pkg::PDF_FLOOR)

    `FGLS_ASSERT_IMPLY(a_reflect_gray, clk, rst_n, valid && lobe == fgls_pkg::LOBE_REFLECT, fresnel != '0 && weight_red == weight_green && weight_green == weight_blue && (pdf == weight_red || pdf == fgls_pkg::PDF_FLOOR))

endmodule

bind fresnel_glass_lobe_select fgls_checker u_fgls_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (result.valid),
    .ready        (result.ready),
    .fresnel      (result.fresnel),
    .lobe         (result.lobe),
    .weight_red   (result.weight_red),
    .weight_green (result.weight_green),
    .weight_blue  (result.weight_blue),
    .pdf          (result.pdf)
);

@@ tb/tb.sv @@
// Testbench for fresnel_glass_lobe_select: samples checked against a fixed-point predictor.
// Depends on fgls_pkg, fgls_sample_if, fgls_result_if and the block itself.
`timescale 1ns / 1ps

typedef struct {
    logic [16:0] fresnel;
    logic [1:0]  lobe;
    logic        delta_flag;
    logic [16:0] weight_red;
    logic [16:0] weight_green;
    logic [16:0] weight_blue;
    logic [16:0] pdf;
} lobe_result_t;

class lobe_scoreboard;
    longint unsigned ior_q12, rough_q16, trans_q16, tint_r, tint_g, tint_b;
    lobe_result_t    pending_results[$];
    int              errors;

    function new();
        ior_q12   = fgls_pkg::IOR_RESET;
        rough_q16 = 0;
        trans_q16 = 65536;
        tint_r    = 65536;
        tint_g    = 65536;
        tint_b    = 65536;
        errors    = 0;
    endfunction

    function void set_reg(logic [2:0] idx, longint unsigned val);
        case (idx)
            fgls_pkg::REG_IOR:          ior_q12 = val & 64'h3FFF;
            fgls_pkg::REG_ROUGHNESS:    rough_q16 = val & 64'h1FFFF;
            fgls_pkg::REG_TRANSMISSION: trans_q16 = val & 64'h1FFFF;
            fgls_pkg::REG_TINT_RED:     tint_r = val & 64'h1FFFF;
            fgls_pkg::REG_TINT_GREEN:   tint_g = val & 64'h1FFFF;
            fgls_pkg::REG_TINT_BLUE:    tint_b = val & 64'h1FFFF;
            default: ;
        endcase
    endfunction

    function longint unsigned clamp_one(longint unsigned v);
        return (v > 65536) ? 65536 : v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function longint unsigned amp_ratio(longint unsigned x, longint unsigned y);
        longint unsigned diff;
        diff = (x > y) ? x - y : y - x;
        if (x + y == 0) return 65536;
        return (diff << 16) / (x + y);
    endfunction

    function longint unsigned reflectance(longint unsigned c, longint unsigned eta);
        longint unsigned sin2_t, cos_t, r1, r2;
        sin2_t = (((64'd1 << 30) - c * c) << 24) / (eta * eta);
        if (sin2_t >= (64'd1 << 30)) return 65536;
        cos_t = int_sqrt((64'd1 << 30) - sin2_t);
        r1 = amp_ratio(eta * c, cos_t << 12);
        r2 = amp_ratio(c << 12, eta * cos_t);
        return clamp_one((r1 * r1 + r2 * r2) >> 17);
    endfunction

    function void note_sample(logic [15:0] cos_in, logic [15:0] u);
        lobe_result_t    r;
        longint unsigned c, eta, f, t, total, rn, tn;
        c   = (cos_in > 32768) ? 32768 : cos_in;
        eta = (ior_q12 == 0) ? 1 : ior_q12;
        f   = reflectance(c, eta);
        t   = ((65536 - f) * clamp_one(trans_q16)) >> 16;
        total = f + t;
        r.fresnel    = 17'(f);
        r.delta_flag = (rough_q16 < fgls_pkg::DELTA_LIMIT);
        if (total == 0) begin
            r.lobe = fgls_pkg::LOBE_NONE;
            r.weight_red = '0;
            r.weight_green = '0;
            r.weight_blue = '0;
            r.pdf = fgls_pkg::Q16_ONE;
        end else begin
            rn = (f << 16) / total;
            tn = (t << 16) / total;
            if (u < rn) begin
                r.lobe = fgls_pkg::LOBE_REFLECT;
                r.weight_red = 17'(rn);
                r.weight_green = 17'(rn);
                r.weight_blue = 17'(rn);
                r.pdf = 17'((rn < fgls_pkg::PDF_FLOOR) ? fgls_pkg::PDF_FLOOR : rn);
            end else begin
                r.lobe = fgls_pkg::LOBE_TRANSMIT;
                r.weight_red = 17'((clamp_one(tint_r) * tn) >> 16);
                r.weight_green = 17'((clamp_one(tint_g) * tn) >> 16);
                r.weight_blue = 17'((clamp_one(tint_b) * tn) >> 16);
                r.pdf = 17'((tn < fgls_pkg::PDF_FLOOR) ? fgls_pkg::PDF_FLOOR : tn);
            end
        end
        pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [16:0] exp_v, logic [16:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_result(lobe_result_t act);
        lobe_result_t exp_r;
        if (pending_results.size() == 0) begin
            $error("result with no sample outstanding");
            errors++;
            return;
        end
        exp_r = pending_results.pop_front();
        compare_field("fresnel", exp_r.fresnel, act.fresnel);
        compare_field("lobe", 17'(exp_r.lobe), 17'(act.lobe));
        compare_field("delta_flag", 17'(exp_r.delta_flag), 17'(act.delta_flag));
        compare_field("weight_red", exp_r.weight_red, act.weight_red);
        compare_field("weight_green", exp_r.weight_green, act.weight_green);
        compare_field("weight_blue", exp_r.weight_blue, act.weight_blue);
        compare_field("pdf", exp_r.pdf, act.pdf);
    endfunction
endclass

module tb;
    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [fgls_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fgls_pkg::CFG_W-1:0]     cfg_data;
    bit                             no_gaps;
    bit                             stall_req;
    bit                             stall_done;
    int                             cycles;

    fgls_sample_if smp();
    fgls_result_if res();
    lobe_scoreboard lobe_sb;

    fresnel_glass_lobe_select dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (smp),
        .result    (res)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        smp.valid = 1'b0;
        smp.cos_incident = '0;
        smp.rand_u = '0;
        res.ready = 1'b0;
        lobe_sb = new();
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 200000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Sample the handshakes and score transactions.
    always @(posedge clk)
    begin
        lobe_result_t act;
        if (rst_n && smp.valid && smp.ready)
            lobe_sb.note_sample(smp.cos_incident, smp.rand_u);
        if (rst_n && res.valid && res.ready)
        begin
            act.fresnel = res.fresnel;
            act.lobe = res.lobe;
            act.delta_flag = res.delta_flag;
            act.weight_red = res.weight_red;
            act.weight_green = res.weight_green;
            act.weight_blue = res.weight_blue;
            act.pdf = res.pdf;
            lobe_sb.check_result(act);
        end
    end

    // Drive the receiver; hold off for a long stretch once when asked.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_req && !stall_done)
            begin
                res.ready <= 1'b0;
                repeat (400) @(posedge clk);
                stall_done = 1'b1;
                res.ready <= 1'b1;
            end
            else
                res.ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 16);
        end
    end

    task automatic write_regs(input logic [fgls_pkg::CFG_W-1:0] v_ior,
                              input logic [fgls_pkg::CFG_W-1:0] v_rough,
                              input logic [fgls_pkg::CFG_W-1:0] v_trans,
                              input logic [fgls_pkg::CFG_W-1:0] v_r,
                              input logic [fgls_pkg::CFG_W-1:0] v_g,
                              input logic [fgls_pkg::CFG_W-1:0] v_b);
        logic [fgls_pkg::CFG_W-1:0]     vals[6];
        logic [fgls_pkg::CFG_IDX_W-1:0] idx[6];
        vals = '{v_ior, v_rough, v_trans, v_r, v_g, v_b};
        idx = '{fgls_pkg::REG_IOR, fgls_pkg::REG_ROUGHNESS, fgls_pkg::REG_TRANSMISSION,
                fgls_pkg::REG_TINT_RED, fgls_pkg::REG_TINT_GREEN, fgls_pkg::REG_TINT_BLUE};
        for (int i = 0; i < 6; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            lobe_sb.set_reg(idx[i], vals[i]);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    // Call at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_sample(input logic [15:0] c, input logic [15:0] u);
        if (!no_gaps && $urandom_range(99) < 16)
        begin
            smp.valid <= 1'b0;
            @(posedge clk);
        end
        smp.valid <= 1'b1;
        smp.cos_incident <= c;
        smp.rand_u <= u;
        do
            @(negedge clk);
        while (!smp.ready);
        @(posedge clk);
    endtask

    task automatic drain_results();
        smp.valid <= 1'b0;
        @(posedge clk);
        while (lobe_sb.pending_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic run_phase(input int n_rand);
        logic [15:0] edge_cos[6];
        edge_cos = '{16'd0, 16'd1, 16'd16384, 16'd32767, 16'd32768, 16'd65535};
        for (int i = 0; i < 6; i++)
            send_sample(edge_cos[i], (i % 2 == 0) ? 16'd0 : 16'd65535);
        for (int i = 0; i < n_rand; i++)
            send_sample(($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768)),
                        16'($urandom));
        drain_results();
    endtask

    initial
    begin
        cycles = 0;
        no_gaps = 1'b0;
        stall_req = 1'b0;
        stall_done = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_phase(40);
        write_regs(17'd4096, 17'd131071, 17'd0, 17'd0, 17'd0, 17'd0);
        run_phase(60);
        write_regs(17'd0, 17'd1310, 17'd131071, 17'd131071, 17'd1, 17'd65535);
        stall_req = 1'b1;
        run_phase(200);
        write_regs(17'd16383, 17'd1311, 17'd65535, 17'd32768, 17'd16384, 17'd8192);
        no_gaps = 1'b1;
        run_phase(150);
        no_gaps = 1'b0;
        write_regs(17'd1, 17'd65536, 17'd1, 17'd65535, 17'd65535, 17'd0);
        run_phase(40);
        write_regs(17'd6144, 17'd0, 17'd65536, 17'd65536, 17'd65536, 17'd65536);
        run_phase(60);
        for (int p = 0; p < 4; p++)
        begin
            write_regs(17'($urandom), 17'($urandom), 17'($urandom_range(131071)),
                       17'($urandom), 17'($urandom), 17'($urandom_range(65536)));
            run_phase(60);
        end

        if (lobe_sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    final
    begin
        if (lobe_sb.pending_results.size() != 0)
            $error("%0d results never arrived", lobe_sb.pending_results.size());
    end
endmodule

@@ fresnel_glass_lobe_select.f @@
+incdir+rtl
rtl/fgls_pkg.sv
rtl/fgls_sample_if.sv
rtl/fgls_result_if.sv
rtl/fgls_div_pipe.sv
rtl/fgls_sqrt_pipe.sv
rtl/fresnel_glass_lobe_select.sv
rtl/fgls_checker.sv
tb/tb.sv
